// ===== hdl/ymr_pkg.sv =====
package ymr_pkg;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_C   = 8'h43;

    localparam logic [3:0] ST_ACCEPTED  = 4'd0;
    localparam logic [3:0] ST_EOT       = 4'd1;
    localparam logic [3:0] ST_CANCELLED = 4'd2;
    localparam logic [3:0] ST_BAD_HDR   = 4'd3;
    localparam logic [3:0] ST_BAD_CMP   = 4'd4;
    localparam logic [3:0] ST_BAD_CRC   = 4'd5;
    localparam logic [3:0] ST_BAD_SEQ   = 4'd6;
    localparam logic [3:0] ST_DUPLICATE = 4'd7;
    localparam logic [3:0] ST_TIMEOUT   = 4'd8;
    localparam logic [3:0] ST_HANDSHAKE = 4'd9;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    localparam int SHORT_PAYLOAD = 128;
    localparam int LONG_PAYLOAD  = 1024;
    localparam int CNT_W         = $clog2(LONG_PAYLOAD) + 1;
    localparam int IDX_W         = $clog2(LONG_PAYLOAD);

    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [7:0]  MAX_RETRIES_RST = 8'd10;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH) + 1;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [IDX_W-1:0] index;
        logic             name;
        logic [3:0]       status;
        logic             send;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hdl/ymodem_receiver.sv =====
// channel   signals                                   request
// in        in_valid in_ready opcode rx_byte          one event
// out       out_valid out_ready result_kind data_byte  one result
//           payload_index is_name_packet status
//           session_end last_of_run
// cfg       cfg_wr_en cfg_wr_data                     max_retries write
//
// One event per cycle while the result queue has room: input register, then
// the framer updates and queues its results. A name-packet verdict queues two
// results (ACK, 'C'); the 4-entry result queue drains one per cycle while
// out_ready is high, and in_ready drops while fewer than two slots would be
// free, so out_ready low stalls the input register once it fills.
// Reset is asynchronous; max_retries resets to 10, no clearing pass.
module ymodem_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  data_byte,
    output logic [9:0]  payload_index,
    output logic        is_name_packet,
    output logic [3:0]  status,
    output logic        session_end,
    output logic        last_of_run
);

    logic                         stage_valid_reg, stage_valid_next;
    logic [1:0]                   op_reg;
    logic [7:0]                   byte_reg;
    logic [7:0]                   max_retries_reg;
    logic                         stage_fire, room;
    logic [ymr_pkg::QCNT_W-1:0]   level;
    ymr_pkg::push_t               push;
    ymr_pkg::res_t                head;

    assign stage_fire       = stage_valid_reg && room;
    assign in_ready         = !stage_valid_reg || stage_fire;
    assign stage_valid_next = (in_valid && in_ready) || (stage_valid_reg && !stage_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            max_retries_reg <= ymr_pkg::MAX_RETRIES_RST;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (cfg_wr_en)
                max_retries_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= opcode;
            byte_reg <= rx_byte;
        end
    end

    ymr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (stage_fire),
        .op          (op_reg),
        .b           (byte_reg),
        .max_retries (max_retries_reg),
        .push        (push)
    );

    ymr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (out_ready),
        .room     (room),
        .nonempty (out_valid),
        .level    (level),
        .head     (head)
    );

    assign result_kind    = head.kind;
    assign data_byte      = head.data;
    assign payload_index  = head.index;
    assign is_name_packet = head.name;
    assign status         = head.status;
    assign session_end    = head.send;
    assign last_of_run    = head.last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        level <= ymr_pkg::QCNT_W'(ymr_pkg::QDEPTH))
        else $error("result queue overflow");

    a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> stage_fire)
        else $error("result pushed without an event");

    a_end_is_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && session_end) |-> (result_kind == ymr_pkg::KIND_REPLY))
        else $error("session end on a payload byte");

    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == ymr_pkg::KIND_PAYLOAD) |->
            (status == ymr_pkg::ST_ACCEPTED && last_of_run))
        else $error("payload byte with a verdict");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !room) |=> (stage_valid_reg && $stable(op_reg)
            && $stable(byte_reg)))
        else $error("stalled event lost");

endmodule

// ===== hdl/ymr_core.sv =====
module ymr_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [1:0]          op,
    input  logic [7:0]          b,
    input  logic [7:0]          max_retries,
    output ymr_pkg::push_t      push
);

    localparam logic [2:0] FR_HEAD = 3'd0;
    localparam logic [2:0] FR_BLK  = 3'd1;
    localparam logic [2:0] FR_CMP  = 3'd2;
    localparam logic [2:0] FR_DATA = 3'd3;
    localparam logic [2:0] FR_CRCH = 3'd4;
    localparam logic [2:0] FR_CRCL = 3'd5;

    logic                        session_reg, session_next;
    logic [2:0]                  frame_reg, frame_next;
    logic [7:0]                  blk_reg, blk_next;
    logic [ymr_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        long_reg, long_next;
    logic [15:0]                 crc_reg, crc_next;
    logic [7:0]                  crch_reg, crch_next;
    logic [7:0]                  seq_reg, seq_next;
    logic [7:0]                  retry_reg, retry_next;
    logic [7:0]                  lastrep_reg, lastrep_next;
    logic                        name_reg, name_next;

    logic                        rep, rep_end, err, two;
    logic [7:0]                  rep_byte, err_soft, retry_inc;
    logic [3:0]                  rep_status, err_status;
    logic                        rep_name, err_can;
    logic [ymr_pkg::CNT_W-1:0]   size, cnt_inc;

    always_comb
    begin
        session_next = session_reg;
        frame_next   = frame_reg;
        blk_next     = blk_reg;
        cnt_next     = cnt_reg;
        long_next    = long_reg;
        crc_next     = crc_reg;
        crch_next    = crch_reg;
        seq_next     = seq_reg;
        retry_next   = retry_reg;
        lastrep_next = lastrep_reg;
        name_next    = name_reg;
        rep          = 1'b0;
        rep_end      = 1'b0;
        rep_byte     = ymr_pkg::B_NAK;
        rep_status   = ymr_pkg::ST_ACCEPTED;
        rep_name     = name_reg;
        err          = 1'b0;
        err_soft     = ymr_pkg::B_NAK;
        err_status   = ymr_pkg::ST_ACCEPTED;
        two          = 1'b0;
        push         = '0;
        size         = long_reg ? ymr_pkg::CNT_W'(ymr_pkg::LONG_PAYLOAD)
                                : ymr_pkg::CNT_W'(ymr_pkg::SHORT_PAYLOAD);
        cnt_inc      = cnt_reg + 1'b1;
        retry_inc    = (retry_reg != 8'hff) ? retry_reg + 8'd1 : retry_reg;
        err_can      = (retry_inc >= max_retries);

        if (fire)
        begin
            case (op)
                ymr_pkg::OP_START:
                begin
                    session_next = 1'b1;
                    frame_next   = FR_HEAD;
                    retry_next   = '0;
                    name_next    = 1'b1;
                    seq_next     = '0;
                    rep          = 1'b1;
                    rep_name     = 1'b1;
                    rep_byte     = ymr_pkg::B_C;
                    rep_status   = ymr_pkg::ST_HANDSHAKE;
                end
                ymr_pkg::OP_TIMEOUT:
                begin
                    if (session_reg)
                    begin
                        frame_next = FR_HEAD;
                        if (name_reg)
                        begin
                            rep        = 1'b1;
                            rep_byte   = ymr_pkg::B_C;
                            rep_status = ymr_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            err        = 1'b1;
                            err_status = ymr_pkg::ST_TIMEOUT;
                        end
                    end
                end
                ymr_pkg::OP_BYTE:
                begin
                    if (session_reg)
                    begin
                        case (frame_reg)
                            FR_HEAD:
                            begin
                                if (b == ymr_pkg::B_EOT)
                                begin
                                    rep        = 1'b1;
                                    rep_status = ymr_pkg::ST_EOT;
                                    if (lastrep_reg == ymr_pkg::B_ACK)
                                        rep_byte = ymr_pkg::B_NAK;
                                    else
                                    begin
                                        rep_byte = ymr_pkg::B_ACK;
                                        rep_end  = 1'b1;
                                    end
                                end
                                else if (b == ymr_pkg::B_CAN)
                                begin
                                    rep        = 1'b1;
                                    rep_byte   = ymr_pkg::B_ACK;
                                    rep_status = ymr_pkg::ST_CANCELLED;
                                    rep_end    = 1'b1;
                                end
                                else if (b == ymr_pkg::B_SOH || b == ymr_pkg::B_STX)
                                begin
                                    long_next  = (b == ymr_pkg::B_STX);
                                    frame_next = FR_BLK;
                                end
                                else
                                begin
                                    err        = 1'b1;
                                    err_status = ymr_pkg::ST_BAD_HDR;
                                end
                            end
                            FR_BLK:
                            begin
                                blk_next   = b;
                                frame_next = FR_CMP;
                            end
                            FR_CMP:
                            begin
                                if ((blk_reg ^ b) != 8'hff)
                                begin
                                    frame_next = FR_HEAD;
                                    err        = 1'b1;
                                    err_status = ymr_pkg::ST_BAD_CMP;
                                end
                                else
                                begin
                                    cnt_next   = '0;
                                    crc_next   = '0;
                                    frame_next = FR_DATA;
                                end
                            end
                            FR_DATA:
                            begin
                                push.count    = 2'd1;
                                push.r0.kind  = ymr_pkg::KIND_PAYLOAD;
                                push.r0.data  = b;
                                push.r0.index = cnt_reg[ymr_pkg::IDX_W-1:0];
                                push.r0.name  = name_reg;
                                push.r0.last  = 1'b1;
                                crc_next      = ymr_pkg::crc_step(crc_reg, b);
                                cnt_next      = cnt_inc;
                                if (cnt_inc >= size)
                                    frame_next = FR_CRCH;
                            end
                            FR_CRCH:
                            begin
                                crch_next  = b;
                                frame_next = FR_CRCL;
                            end
                            FR_CRCL:
                            begin
                                frame_next = FR_HEAD;
                                if (crc_reg != {crch_reg, b})
                                begin
                                    err        = 1'b1;
                                    err_status = ymr_pkg::ST_BAD_CRC;
                                end
                                else if (blk_reg == seq_reg)
                                begin
                                    seq_next   = seq_reg + 8'd1;
                                    retry_next = '0;
                                    rep        = 1'b1;
                                    rep_byte   = ymr_pkg::B_ACK;
                                    if (name_reg)
                                    begin
                                        two       = 1'b1;
                                        name_next = 1'b0;
                                    end
                                end
                                else if (blk_reg == seq_reg - 8'd1)
                                begin
                                    err        = 1'b1;
                                    err_soft   = ymr_pkg::B_ACK;
                                    err_status = ymr_pkg::ST_DUPLICATE;
                                end
                                else
                                begin
                                    err        = 1'b1;
                                    err_status = ymr_pkg::ST_BAD_SEQ;
                                end
                            end
                            default:
                            begin
                                frame_next = FR_HEAD;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (err)
        begin
            retry_next = retry_inc;
            rep        = 1'b1;
            rep_status = err_status;
            rep_byte   = err_can ? ymr_pkg::B_CAN : err_soft;
            rep_end    = err_can;
        end

        if (rep)
        begin
            push.count     = 2'd1;
            push.r0.kind   = ymr_pkg::KIND_REPLY;
            push.r0.data   = rep_byte;
            push.r0.index  = '0;
            push.r0.name   = rep_name;
            push.r0.status = rep_status;
            push.r0.send   = rep_end;
            push.r0.last   = !two;
            lastrep_next   = rep_byte;
            if (rep_end)
            begin
                session_next = 1'b0;
                frame_next   = FR_HEAD;
            end
        end

        // name packet: ACK then 'C'
        if (two)
        begin
            push.count     = 2'd2;
            push.r1.kind   = ymr_pkg::KIND_REPLY;
            push.r1.data   = ymr_pkg::B_C;
            push.r1.index  = '0;
            push.r1.name   = name_reg;
            push.r1.status = ymr_pkg::ST_ACCEPTED;
            push.r1.send   = 1'b0;
            push.r1.last   = 1'b1;
            lastrep_next   = ymr_pkg::B_ACK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg <= 1'b0;
            frame_reg   <= FR_HEAD;
            blk_reg     <= '0;
            cnt_reg     <= '0;
            long_reg    <= 1'b0;
            crc_reg     <= '0;
            crch_reg    <= '0;
            seq_reg     <= '0;
            retry_reg   <= '0;
            lastrep_reg <= '0;
            name_reg    <= 1'b1;
        end
        else
        begin
            session_reg <= session_next;
            frame_reg   <= frame_next;
            blk_reg     <= blk_next;
            cnt_reg     <= cnt_next;
            long_reg    <= long_next;
            crc_reg     <= crc_next;
            crch_reg    <= crch_next;
            seq_reg     <= seq_next;
            retry_reg   <= retry_next;
            lastrep_reg <= lastrep_next;
            name_reg    <= name_next;
        end
    end

endmodule

// ===== hdl/ymr_fifo.sv =====
module ymr_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ymr_pkg::push_t               push,
    input  logic                         pop,
    output logic                         room,
    output logic                         nonempty,
    output logic [ymr_pkg::QCNT_W-1:0]   level,
    output ymr_pkg::res_t                head
);

    ymr_pkg::res_t                mem [ymr_pkg::QDEPTH];
    logic [ymr_pkg::QPTR_W-1:0]   wr_reg, wr_next;
    logic [ymr_pkg::QPTR_W-1:0]   rd_reg, rd_next;
    logic [ymr_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [ymr_pkg::QPTR_W-1:0]   wr_p1;
    logic                         do_pop;

    assign nonempty = (cnt_reg != '0);
    assign room     = (cnt_reg <= ymr_pkg::QCNT_W'(ymr_pkg::QDEPTH - 2));
    assign level    = cnt_reg;
    assign head     = mem[rd_reg];
    assign do_pop   = pop && nonempty;
    assign wr_p1    = wr_reg + 1'b1;

    always_comb
    begin
        wr_next  = wr_reg + ymr_pkg::QPTR_W'(push.count);
        rd_next  = rd_reg + ymr_pkg::QPTR_W'(do_pop);
        cnt_next = cnt_reg + ymr_pkg::QCNT_W'(push.count) - ymr_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_reg] <= push.r0;
        if (push.count == 2'd2)
            mem[wr_p1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== tb/ymr_tb_pkg.sv =====
package ymr_tb_pkg;

    import ymr_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        AWAIT_HDR,
        AWAIT_BLK,
        AWAIT_CMP,
        IN_DATA,
        AWAIT_CRC_HI,
        AWAIT_CRC_LO
    } frame_e;

    // CRC-16/XMODEM, one byte, bit-serial MSB first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] v;
        v = crc;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[15] ^ b[i])
                v = {v[14:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[14:0], 1'b0};
        end
        return v;
    endfunction

    class ymodem_tracker;

        logic [7:0]  retry_limit;
        logic        in_session;
        frame_e      frame;
        logic [7:0]  blk_num;
        int          byte_count;
        logic        is_long;
        logic [15:0] crc_run;
        logic [7:0]  crc_hi;
        logic [7:0]  next_seq;
        logic [7:0]  retries;
        logic [7:0]  prev_reply;
        logic        naming;
        res_t        awaited[$];
        int          mismatches;

        function new();
            retry_limit = MAX_RETRIES_RST;
            in_session  = 1'b0;
            frame       = AWAIT_HDR;
            blk_num     = '0;
            byte_count  = 0;
            is_long     = 1'b0;
            crc_run     = '0;
            crc_hi      = '0;
            next_seq    = '0;
            retries     = '0;
            prev_reply  = '0;
            naming      = 1'b1;
            mismatches  = 0;
        endfunction

        function void set_retry_limit(input logic [7:0] v);
            retry_limit = v;
        endfunction

        function void emit(input logic kind, input logic [7:0] data, input logic [9:0] idx,
                           input logic [3:0] st, input logic fin);
            res_t r;
            r.kind   = kind;
            r.data   = data;
            r.index  = idx;
            r.name   = naming;
            r.status = st;
            r.send   = fin;
            r.last   = 1'b0;
            awaited.push_back(r);
        endfunction

        function void answer(input logic [7:0] code, input logic [3:0] st, input logic fin);
            emit(KIND_REPLY, code, '0, st, fin);
            prev_reply = code;
            if (fin)
            begin
                in_session = 1'b0;
                frame      = AWAIT_HDR;
            end
        endfunction

        function void fault(input logic [3:0] st, input logic [7:0] mild);
            if (retries != 8'hff)
                retries++;
            if (retries >= retry_limit)
                answer(B_CAN, st, 1'b1);
            else
                answer(mild, st, 1'b0);
        endfunction

        function void take_byte(input logic [7:0] b);
            case (frame)
                AWAIT_HDR:
                begin
                    if (b == B_EOT)
                    begin
                        if (prev_reply == B_ACK)
                            answer(B_NAK, ST_EOT, 1'b0);
                        else
                            answer(B_ACK, ST_EOT, 1'b1);
                    end
                    else if (b == B_CAN)
                        answer(B_ACK, ST_CANCELLED, 1'b1);
                    else if (b == B_SOH || b == B_STX)
                    begin
                        is_long = (b == B_STX);
                        frame   = AWAIT_BLK;
                    end
                    else
                        fault(ST_BAD_HDR, B_NAK);
                end
                AWAIT_BLK:
                begin
                    blk_num = b;
                    frame   = AWAIT_CMP;
                end
                AWAIT_CMP:
                begin
                    if ((blk_num ^ b) != 8'hff)
                    begin
                        frame = AWAIT_HDR;
                        fault(ST_BAD_CMP, B_NAK);
                    end
                    else
                    begin
                        byte_count = 0;
                        crc_run    = '0;
                        frame      = IN_DATA;
                    end
                end
                IN_DATA:
                begin
                    emit(KIND_PAYLOAD, b, 10'(byte_count), ST_ACCEPTED, 1'b0);
                    crc_run = crc16_update(crc_run, b);
                    byte_count++;
                    if (byte_count >= (is_long ? LONG_PAYLOAD : SHORT_PAYLOAD))
                        frame = AWAIT_CRC_HI;
                end
                AWAIT_CRC_HI:
                begin
                    crc_hi = b;
                    frame  = AWAIT_CRC_LO;
                end
                default:
                begin
                    frame = AWAIT_HDR;
                    if (crc_run != {crc_hi, b})
                        fault(ST_BAD_CRC, B_NAK);
                    else if (blk_num == next_seq)
                    begin
                        next_seq++;
                        retries = '0;
                        answer(B_ACK, ST_ACCEPTED, 1'b0);
                        if (naming)
                        begin
                            answer(B_C, ST_ACCEPTED, 1'b0);
                            naming     = 1'b0;
                            prev_reply = B_ACK;
                        end
                    end
                    else if (blk_num == 8'(next_seq - 8'd1))
                        fault(ST_DUPLICATE, B_ACK);
                    else
                        fault(ST_BAD_SEQ, B_NAK);
                end
            endcase
        endfunction

        function void take_request(input logic [1:0] op, input logic [7:0] b);
            int   queued;
            res_t tail;
            queued = awaited.size();
            if (op == OP_START)
            begin
                in_session = 1'b1;
                frame      = AWAIT_HDR;
                retries    = '0;
                naming     = 1'b1;
                next_seq   = '0;
                answer(B_C, ST_HANDSHAKE, 1'b0);
            end
            else if (op == OP_TIMEOUT && in_session)
            begin
                frame = AWAIT_HDR;
                if (naming)
                    answer(B_C, ST_TIMEOUT, 1'b0);
                else
                    fault(ST_TIMEOUT, B_NAK);
            end
            else if (op == OP_BYTE && in_session)
                take_byte(b);
            if (awaited.size() > queued)
            begin
                tail = awaited.pop_back();
                tail.last = 1'b1;
                awaited.push_back(tail);
            end
        endfunction

        function void check_field(input string field, input int unsigned want,
                                  input int unsigned got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(input logic kind, input logic [7:0] data,
                                   input logic [9:0] idx, input logic name,
                                   input logic [3:0] st, input logic fin, input logic last);
            res_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: kind %0d data_byte 0x%0h", kind, data);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            check_field("result_kind", want.kind, kind);
            check_field("data_byte", want.data, data);
            check_field("payload_index", want.index, idx);
            check_field("is_name_packet", want.name, name);
            check_field("status", want.status, st);
            check_field("session_end", want.send, fin);
            check_field("last_of_run", want.last, last);
        endfunction

    endclass

endpackage

// ===== tb/tb.sv =====
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ymr_pkg::*;
    import ymr_tb_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] opcode = OP_BYTE;
    logic [7:0] rx_byte = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       result_kind;
    logic [7:0] data_byte;
    logic [9:0] payload_index;
    logic       is_name_packet;
    logic [3:0] status;
    logic       session_end;
    logic       last_of_run;

    ymodem_tracker tracker;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int useful_items = 0;
    int stall_cycles = 0;

    ymodem_receiver DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .data_byte      (data_byte),
        .payload_index  (payload_index),
        .is_name_packet (is_name_packet),
        .status         (status),
        .session_end    (session_end),
        .last_of_run    (last_of_run)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.match_result(result_kind, data_byte, payload_index, is_name_packet,
                                     status, session_end, last_of_run);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL ymodem_receiver");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        if (op != OP_UNUSED && (op == OP_START || tracker.in_session))
            useful_items++;
        in_valid <= 1'b1;
        opcode   <= op;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_request(op, b);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_retry_limit(input logic [7:0] v);
        quiesce();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_retry_limit(v);
    endtask

    // cut >= 0: timeout after that many payload bytes
    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] blk, input bit bad_cmp,
                               input bit bad_crc, input int cut);
        logic [15:0] crc;
        logic [7:0]  b;
        int          len;
        len = (hdr == B_STX) ? LONG_PAYLOAD : SHORT_PAYLOAD;
        crc = '0;
        send_request(OP_BYTE, hdr);
        send_request(OP_BYTE, blk);
        if (bad_cmp)
        begin
            send_request(OP_BYTE, ~blk ^ (8'h01 << $urandom_range(7)));
            return;
        end
        send_request(OP_BYTE, ~blk);
        for (int i = 0; i < len; i++)
        begin
            if (cut == i)
            begin
                send_request(OP_TIMEOUT, 8'($urandom));
                return;
            end
            b   = 8'($urandom);
            crc = crc16_update(crc, b);
            send_request(OP_BYTE, b);
        end
        if (bad_crc)
            crc ^= 16'h0001 << $urandom_range(15);
        send_request(OP_BYTE, crc[15:8]);
        send_request(OP_BYTE, crc[7:0]);
    endtask

    task automatic random_traffic(input int budget);
        int         target;
        int         pick;
        logic [7:0] blk;
        target = useful_items + budget;
        while (useful_items < target)
        begin
            if (!tracker.in_session)
            begin
                if ($urandom_range(9) == 0)
                    send_request($urandom_range(1) ? OP_BYTE : OP_TIMEOUT, 8'($urandom));
                else
                    send_request(OP_START, 8'($urandom));
                continue;
            end
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                case ($urandom_range(9))
                    7: blk = tracker.next_seq - 8'd1;
                    8: blk = 8'($urandom);
                    default: blk = tracker.next_seq;
                endcase
                send_packet(B_SOH, blk, $urandom_range(9) == 0, $urandom_range(6) == 0, -1);
            end
            else if (pick < 55)
                send_packet($urandom_range(1) ? B_SOH : B_STX, tracker.next_seq, 1'b0, 1'b0,
                            $urandom_range(8));
            else if (pick < 63)
                send_request(OP_BYTE, B_EOT);
            else if (pick < 66)
                send_request(OP_BYTE, B_CAN);
            else if (pick < 74)
                send_request(OP_TIMEOUT, 8'($urandom));
            else if (pick < 79)
                send_request(OP_START, 8'($urandom));
            else if (pick < 92)
                send_request(OP_BYTE, 8'($urandom));
            else
                send_request(OP_UNUSED, 8'($urandom));
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_retry_limit(8'd3);
        in_idle_pct  = 12;
        out_idle_pct = 74;
        // idle: bytes, timeouts and unused opcodes are dropped
        send_request(OP_BYTE, B_SOH);
        send_request(OP_TIMEOUT, 8'hff);
        send_request(OP_UNUSED, 8'h00);
        send_request(OP_START, 8'h00);
        send_request(OP_TIMEOUT, 8'haa);
        send_request(OP_BYTE, 8'h00);
        send_request(OP_BYTE, 8'hff);
        send_request(OP_START, 8'hff);
        // block/complement mismatch
        send_request(OP_BYTE, B_SOH);
        send_request(OP_BYTE, 8'h00);
        send_request(OP_BYTE, 8'h00);
        // long header, one payload byte, then timeout while naming
        send_request(OP_BYTE, B_STX);
        send_request(OP_BYTE, 8'hff);
        send_request(OP_BYTE, 8'h00);
        send_request(OP_BYTE, 8'ha5);
        send_request(OP_TIMEOUT, 8'h5a);
        send_request(OP_BYTE, B_EOT);
        send_request(OP_START, 8'h81);
        send_request(OP_BYTE, B_CAN);
        // retry exhaustion on bad headers
        send_request(OP_START, 8'h7e);
        send_request(OP_BYTE, 8'h7f);
        send_request(OP_BYTE, 8'h80);
        send_request(OP_BYTE, 8'h55);
        send_request(OP_UNUSED, 8'hff);
        random_traffic(25);

        write_retry_limit(8'd255);
        random_traffic(25);

        write_retry_limit(8'd1);
        in_idle_pct  = 74;
        out_idle_pct = 12;
        random_traffic(25);

        write_retry_limit(8'($urandom_range(4, 254)));
        random_traffic(25);

        write_retry_limit(8'd10);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        random_traffic(25);

        write_retry_limit(8'd2);
        send_request(OP_START, 8'($urandom));
        send_packet(B_STX, tracker.next_seq, 1'b0, 1'b0, -1);
        random_traffic(15);

        quiesce();
        if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
            $display("PASS ymodem_receiver");
        else
            $display("FAIL ymodem_receiver");
        $finish;
    end

endmodule
